@@ design/tei_pkg.sv @@
package tei_pkg;

	localparam int MAIN_KNOTS  = 64;
	localparam int SUB_KNOTS   = 64;
	localparam int MAIN_AW     = $clog2(MAIN_KNOTS);
	localparam int SUB_AW      = $clog2(SUB_KNOTS);
	localparam int COUNT_W     = 7;
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam logic CFG_MAIN_COUNT = 1'b0;
	localparam logic CFG_SUB_COUNT  = 1'b1;

	typedef enum logic [1:0] {
		OP_WR_MAIN = 2'd0,
		OP_WR_SUB  = 2'd1,
		OP_QRY_R   = 2'd2,
		OP_QRY_RP  = 2'd3
	} op_t;

	typedef struct packed {
		op_t                operation;
		logic [5:0]         row;
		logic [5:0]         knot;
		logic signed [31:0] knot_coord;
		logic signed [31:0] knot_value;
		logic signed [31:0] query_r;
		logic signed [31:0] query_p;
	} item_t;

	typedef struct packed {
		logic signed [31:0] energy;
		logic               beyond_table;
	} result_t;

	typedef struct packed {
		logic [COUNT_W-1:0] main_n;
		logic [COUNT_W-1:0] sub_n;
	} cfg_t;

	typedef struct packed {
		logic               done;
		logic signed [31:0] energy;
	} lerp_stat_t;

endpackage

@@ design/tei_front.sv @@
module tei_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  tei_pkg::item_t       item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_index,
	input  logic [6:0]           cfg_data,
	input  logic                 q_full,
	output logic                 q_push,
	output tei_pkg::item_t       q_item,
	output tei_pkg::cfg_t        cfg
);

	logic [tei_pkg::COUNT_W-1:0] main_count_q;
	logic [tei_pkg::COUNT_W-1:0] sub_count_q;

	function automatic logic [tei_pkg::COUNT_W-1:0] clamp(
		input logic [tei_pkg::COUNT_W-1:0] v, input int lim);
		logic [tei_pkg::COUNT_W-1:0] r;
		r = v;
		if (v < tei_pkg::COUNT_W'(2)) r = tei_pkg::COUNT_W'(2);
		if (v > tei_pkg::COUNT_W'(lim)) r = tei_pkg::COUNT_W'(lim);
		return r;
	endfunction

	assign cfg_ready = 1'b1;
	assign full      = q_full;
	assign q_push    = push && !q_full;
	assign q_item    = item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_count_q <= tei_pkg::COUNT_W'(64);
			sub_count_q  <= tei_pkg::COUNT_W'(64);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tei_pkg::CFG_MAIN_COUNT: main_count_q <= cfg_data;
				tei_pkg::CFG_SUB_COUNT:  sub_count_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.main_n = clamp(main_count_q, tei_pkg::MAIN_KNOTS);
	assign cfg.sub_n  = clamp(sub_count_q, tei_pkg::SUB_KNOTS);

endmodule

@@ design/tei_queue.sv @@
module tei_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  tei_pkg::item_t wdata,
	output logic           full,
	input  logic           rd,
	output tei_pkg::item_t rdata,
	output logic           empty
);

	tei_pkg::item_t                ent_q [tei_pkg::QUEUE_DEPTH];
	logic [tei_pkg::QUEUE_AW-1:0]  wp_q;
	logic [tei_pkg::QUEUE_AW-1:0]  rp_q;
	logic [tei_pkg::QUEUE_AW:0]    cnt_q;
	logic                          do_wr;
	logic                          do_rd;

	assign full  = cnt_q == (tei_pkg::QUEUE_AW+1)'(tei_pkg::QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) ent_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr)
				wp_q <= (wp_q == tei_pkg::QUEUE_AW'(tei_pkg::QUEUE_DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (do_rd)
				rp_q <= (rp_q == tei_pkg::QUEUE_AW'(tei_pkg::QUEUE_DEPTH-1)) ? '0 : rp_q + 1'b1;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

@@ design/tei_lerp.sv @@
module tei_lerp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [31:0]   c0,
	input  logic signed [31:0]   c1,
	input  logic signed [31:0]   v0,
	input  logic signed [31:0]   v1,
	input  logic signed [31:0]   x,
	output tei_pkg::lerp_stat_t  stat
);

	typedef enum logic [3:0] {
		L_IDLE = 4'b0001,
		L_MUL  = 4'b0010,
		L_DIV  = 4'b0100,
		L_FIN  = 4'b1000
	} lst_t;

	lst_t               st_q;
	logic [31:0]        a_q;
	logic [31:0]        b_q;
	logic [31:0]        d_q;
	logic               neg_q;
	logic signed [31:0] v0_q;
	logic [63:0]        dvd_q;
	logic [31:0]        rem_q;
	logic [5:0]         cnt_q;

	logic signed [32:0] den;
	logic signed [32:0] diff;
	logic signed [32:0] dr;
	logic [32:0]        rem_n;
	logic               qbit;
	logic [40:0]        qm;
	logic signed [41:0] sum;

	assign den  = 33'(c1) - 33'(c0);
	assign diff = 33'(v1) - 33'(v0);
	assign dr   = 33'(x) - 33'(c0);

	assign rem_n = {rem_q, dvd_q[63]};
	assign qbit  = rem_n >= {1'b0, d_q};

	assign qm  = (dvd_q > 64'(41'h100_0000_0000)) ? 41'h100_0000_0000 : dvd_q[40:0];
	assign sum = neg_q ? 42'(v0_q) - $signed({1'b0, qm}) : 42'(v0_q) + $signed({1'b0, qm});

	always_comb begin
		stat.done = st_q == L_FIN;
		if (sum > 42'sd2147483647) stat.energy = 32'h7FFF_FFFF;
		else if (sum < -42'sd2147483648) stat.energy = 32'h8000_0000;
		else stat.energy = sum[31:0];
	end

	always_ff @(posedge clk) begin
		case (st_q)
			L_IDLE: begin
				if (start) begin
					a_q   <= diff[32] ? 32'(-diff) : diff[31:0];
					b_q   <= dr[32] ? 32'(-dr) : dr[31:0];
					d_q   <= den[32] ? 32'(-den) : den[31:0];
					neg_q <= diff[32] ^ dr[32] ^ den[32];
					v0_q  <= v0;
					dvd_q <= '0;
				end
			end
			L_MUL: begin
				dvd_q <= 64'(a_q) * 64'(b_q);
				rem_q <= '0;
				cnt_q <= '0;
			end
			L_DIV: begin
				rem_q <= qbit ? 32'(rem_n - {1'b0, d_q}) : rem_n[31:0];
				dvd_q <= {dvd_q[62:0], qbit};
				cnt_q <= cnt_q + 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= L_IDLE;
		end else begin
			case (st_q)
				L_IDLE: if (start) begin
					st_q <= (den == '0 || diff == '0 || dr == '0) ? L_FIN : L_MUL;
				end
				L_MUL: st_q <= L_DIV;
				L_DIV: if (cnt_q == 6'd63) st_q <= L_FIN;
				L_FIN: st_q <= L_IDLE;
				default: st_q <= L_IDLE;
			endcase
		end
	end

endmodule

@@ design/tei_back.sv @@
module tei_back (
	input  logic           clk,
	input  logic           arst_n,
	input  tei_pkg::cfg_t  cfg,
	input  logic           q_empty,
	input  tei_pkg::item_t q_item,
	output logic           q_pop,
	output logic           empty,
	input  logic           pop,
	output tei_pkg::result_t result
);

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_LAST  = 11'b000_0000_0010,
		ST_LASTW = 11'b000_0000_0100,
		ST_SRCH  = 11'b000_0000_1000,
		ST_SRCHW = 11'b000_0001_0000,
		ST_RD0   = 11'b000_0010_0000,
		ST_RD1   = 11'b000_0100_0000,
		ST_RD2   = 11'b000_1000_0000,
		ST_GO    = 11'b001_0000_0000,
		ST_LERP  = 11'b010_0000_0000,
		ST_OUT   = 11'b100_0000_0000
	} st_t;

	localparam int SA = tei_pkg::MAIN_AW + tei_pkg::SUB_AW;
	localparam int CW = tei_pkg::COUNT_W;

	logic signed [31:0] main_c [tei_pkg::MAIN_KNOTS];
	logic signed [31:0] main_v [tei_pkg::MAIN_KNOTS];
	logic signed [31:0] sub_c  [tei_pkg::MAIN_KNOTS * tei_pkg::SUB_KNOTS];
	logic signed [31:0] sub_v  [tei_pkg::MAIN_KNOTS * tei_pkg::SUB_KNOTS];

	st_t                 st_q;
	tei_pkg::item_t      job_q;
	logic                tsel_q;
	logic [tei_pkg::MAIN_AW-1:0] row_q;
	logic [CW-1:0]       lo_q;
	logic [CW-1:0]       hi_q;
	logic signed [31:0]  c0_q, v0_q, c1_q, v1_q;
	logic signed [31:0]  mc_q, mv_q, sc_q, sv_q;
	tei_pkg::result_t    res_q;
	tei_pkg::result_t    out_q;
	logic                out_valid_q;

	logic [CW-1:0]       n;
	logic [CW-1:0]       k;
	logic [CW-1:0]       mid;
	logic signed [31:0]  x;
	logic signed [31:0]  rc, rv;
	logic                ah;
	logic signed [32:0]  hden;
	logic signed [33:0]  twice;
	logic                lerp_start;
	logic                load_out;
	tei_pkg::lerp_stat_t lstat;

	assign n     = tsel_q ? cfg.sub_n : cfg.main_n;
	assign x     = tsel_q ? job_q.query_p : job_q.query_r;
	assign mid   = CW'((lo_q + hi_q) >> 1);
	assign rc    = tsel_q ? sc_q : mc_q;
	assign rv    = tsel_q ? sv_q : mv_q;
	assign q_pop = (st_q == ST_IDLE) && !q_empty;

	always_comb begin
		case (st_q)
			ST_LAST: k = n - 1'b1;
			ST_SRCH: k = mid;
			ST_RD0:  k = lo_q;
			ST_RD1:  k = lo_q + 1'b1;
			default: k = lo_q;
		endcase
	end

	assign hden  = 33'(c1_q) - 33'(c0_q);
	assign twice = 34'(33'(x) - 33'(c0_q)) <<< 1;
	always_comb begin
		if (hden > 0) ah = twice > 34'(hden);
		else if (hden < 0) ah = twice < 34'(hden);
		else ah = 1'b0;
	end

	assign lerp_start = (st_q == ST_GO) && !(!tsel_q && job_q.operation == tei_pkg::OP_QRY_RP);
	assign load_out   = (st_q == ST_OUT) && (!out_valid_q || pop);

	always_ff @(posedge clk) begin
		if (q_pop && q_item.operation == tei_pkg::OP_WR_MAIN) begin
			main_c[q_item.knot] <= q_item.knot_coord;
			main_v[q_item.knot] <= q_item.knot_value;
		end
		mc_q <= main_c[k[tei_pkg::MAIN_AW-1:0]];
		mv_q <= main_v[k[tei_pkg::MAIN_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_item.operation == tei_pkg::OP_WR_SUB) begin
			sub_c[{q_item.row, q_item.knot}] <= q_item.knot_coord;
			sub_v[{q_item.row, q_item.knot}] <= q_item.knot_value;
		end
		sc_q <= sub_c[SA'({row_q, k[tei_pkg::SUB_AW-1:0]})];
		sv_q <= sub_v[SA'({row_q, k[tei_pkg::SUB_AW-1:0]})];
	end

	tei_lerp u_lerp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lerp_start),
		.c0     (c0_q),
		.c1     (c1_q),
		.v0     (v0_q),
		.v1     (v1_q),
		.x      (x),
		.stat   (lstat)
	);

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: if (q_pop) job_q <= q_item;
			ST_RD1: begin
				c0_q <= rc;
				v0_q <= rv;
			end
			ST_RD2: begin
				c1_q <= rc;
				v1_q <= rv;
			end
			default: ;
		endcase
		if (st_q == ST_LASTW && x > rc) begin
			res_q.energy       <= '0;
			res_q.beyond_table <= !tsel_q;
		end
		if (st_q == ST_LERP && lstat.done) begin
			res_q.energy       <= lstat.energy;
			res_q.beyond_table <= 1'b0;
		end
		if (load_out) out_q <= res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			tsel_q      <= 1'b0;
			row_q       <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
			case (st_q)
				ST_IDLE: if (q_pop) begin
					tsel_q <= 1'b0;
					if (q_item.operation == tei_pkg::OP_QRY_R ||
					    q_item.operation == tei_pkg::OP_QRY_RP)
						st_q <= ST_LAST;
				end
				ST_LAST: st_q <= ST_LASTW;
				ST_LASTW: begin
					lo_q <= '0;
					hi_q <= n - 1'b1;
					st_q <= (x > rc) ? ST_OUT : ST_SRCH;
				end
				ST_SRCH: st_q <= (hi_q > lo_q + 1'b1) ? ST_SRCHW : ST_RD0;
				ST_SRCHW: begin
					if (x < rc) hi_q <= mid;
					else lo_q <= mid;
					st_q <= ST_SRCH;
				end
				ST_RD0: st_q <= ST_RD1;
				ST_RD1: st_q <= ST_RD2;
				ST_RD2: st_q <= ST_GO;
				ST_GO: begin
					if (lerp_start) begin
						st_q <= ST_LERP;
					end else begin
						row_q  <= tei_pkg::MAIN_AW'(lo_q + CW'(ah));
						tsel_q <= 1'b1;
						st_q   <= ST_LAST;
					end
				end
				ST_LERP: if (lstat.done) st_q <= ST_OUT;
				ST_OUT: if (load_out) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !pop |=> out_valid_q && $stable(out_q))
		else $error("result dropped before pop");
	a_search_span: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_SRCHW |-> hi_q > lo_q + 1'b1)
		else $error("search window collapsed");
	a_search_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_RD0 |-> lo_q + 1'b1 < n + 1'b0 || lo_q + 1'b1 == n - 1'b1)
		else $error("interval beyond table");
	a_lerp_idle: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_LERP |-> !lerp_start)
		else $error("interpolator restarted while busy");

endmodule

@@ design/table_energy_interpolator.sv @@
// channel  | handshake            | payload
// item     | push / full          | item   (tei_pkg::item_t)
// result   | empty / pop          | result (tei_pkg::result_t)
// config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A write item leaves the queue into its table while the back end is idle. A query
// leaves the queue and, per table, checks the last knot (past the last main knot it
// goes straight to the result register), then binary-searches and reads two knots;
// the multiply / restoring-divide unit (bypassed on a zero term) feeds the result.
// Reset clears control state and sets both counts to 64; tables are not cleared.
// A two-entry queue lets items enter while the back end is busy or a result waits.
module table_energy_interpolator (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  tei_pkg::item_t   item,
	output logic             empty,
	input  logic             pop,
	output tei_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_index,
	input  logic [6:0]       cfg_data
);

	logic           q_full;
	logic           q_push;
	tei_pkg::item_t q_wdata;
	logic           q_empty;
	logic           q_pop;
	tei_pkg::item_t q_rdata;
	tei_pkg::cfg_t  cfg;

	tei_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (q_wdata),
		.cfg       (cfg)
	);

	tei_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.rd     (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	tei_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_empty (q_empty),
		.q_item  (q_rdata),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule
